// File: rtl/esu_pkg.sv
// shared types and constants of the escaped string unescaper
`default_nettype none

package esu_pkg;

	// mode register codes (any code past extended sql acts as standard sql)
	localparam logic [1:0] MODE_C   = 2'd0;
	localparam logic [1:0] MODE_EXT = 2'd1;

	// result status codes
	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_BSLASH_END = 2'd1;
	localparam logic [1:0] ST_LONE_QUOTE = 2'd2;

	// character codes
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_QUOTE  = 8'h27;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_SEVEN  = 8'h37;
	localparam logic [7:0] CH_LC_T   = 8'h74;
	localparam logic [7:0] CH_LC_N   = 8'h6e;
	localparam logic [7:0] CH_LC_R   = 8'h72;
	localparam logic [7:0] CH_LC_A   = 8'h61;
	localparam logic [7:0] CH_LC_B   = 8'h62;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0a;
	localparam logic [7:0] CH_CR     = 8'h0d;
	localparam logic [7:0] CH_BEL    = 8'h07;
	localparam logic [7:0] CH_BS     = 8'h08;

	// result buffer depth, at least two
	localparam int OBUF_DEPTH = 4;

	typedef enum logic [2:0] {
		PH_NORMAL,
		PH_BSLASH,
		PH_OCT1,
		PH_OCT2,
		PH_QUOTE,
		PH_DROP
	} phase_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_input;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] status;
		logic       end_of_output;
	} out_word_t;

endpackage

`default_nettype wire

// File: rtl/escaped_string_unescaper_core.sv
// top level of the escaped string unescaper: decode stage and result buffer
`default_nettype none

//  channel | signals                          | direction | word
//  --------+----------------------------------+-----------+-----------------------------
//  src     | src_valid, src_stall, src_word   | in        | raw byte, end_of_input flag
//  res     | res_valid, res_stall, res_word   | out       | byte, status, end_of_output
//  mode    | mode_we, mode_wdata              | in        | 2-bit mode register
//
//  one raw byte accepted per cycle; res_valid rises once its word is in the result
//  buffer; a byte that yields two words takes two slots of the four-word buffer; input
//  keeps one byte per cycle until runs of such bytes or a stalled receiver fill it
//  src_stall rises when a word waits in the input register and the buffer has
//  fewer than two free slots
//  reset: mode is c unescape, phase normal, accumulator zero, both stages empty

module escaped_string_unescaper_core
	import esu_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      mode_we,
	input  wire logic [1:0] mode_wdata,
	input  wire logic      src_valid,
	output logic           src_stall,
	input  wire in_word_t  src_word,
	output logic           res_valid,
	input  wire logic      res_stall,
	output out_word_t      res_word
);

	localparam int PTR_W = (OBUF_DEPTH > 1) ? $clog2(OBUF_DEPTH) : 1;
	localparam int CNT_W = $clog2(OBUF_DEPTH + 1);

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		ptr_inc = (p == PTR_W'(OBUF_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// configuration and decoder state
	logic [1:0] mode_q;
	phase_t     phase_q;
	logic [7:0] acc_q;

	// input register
	logic     valid_s1;
	in_word_t word_s1;

	// result buffer
	out_word_t        obuf_q [OBUF_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	// decode signals
	logic       go;
	logic [7:0] b;
	logic       last;
	logic       is_oct;
	logic       plain_bs;
	logic       plain_q;
	logic       plain_emit;
	logic [7:0] esc_byte;
	logic [7:0] acc_d;
	phase_t     phase_mid;
	phase_t     phase_d;
	out_word_t  r0;
	out_word_t  r1;
	logic [1:0] rcnt;
	logic       q_err;
	logic       tail;
	out_word_t  tail_w;
	logic       pop;

	assign b    = word_s1.in_byte;
	assign last = word_s1.end_of_input;

	// byte classes
	assign is_oct     = (b >= CH_ZERO) && (b <= CH_SEVEN);
	assign plain_bs   = (b == CH_BSLASH) && ((mode_q == MODE_C) || (mode_q == MODE_EXT));
	assign plain_q    = (b == CH_QUOTE) && (mode_q != MODE_C);
	assign plain_emit = !plain_bs && !plain_q;

	// named escapes, anything else stands for itself
	always_comb begin
		case (b)
			CH_LC_T: esc_byte = CH_TAB;
			CH_LC_N: esc_byte = CH_LF;
			CH_LC_R: esc_byte = CH_CR;
			CH_LC_A: esc_byte = CH_BEL;
			CH_LC_B: esc_byte = CH_BS;
			default: esc_byte = b;
		endcase
	end

	// next phase and accumulator
	always_comb begin
		acc_d     = acc_q;
		phase_mid = PH_NORMAL;
		unique case (phase_q) inside
			PH_DROP: begin
				phase_mid = PH_DROP;
			end
			PH_BSLASH: begin
				if (is_oct) begin
					acc_d     = {5'd0, b[2:0]};
					phase_mid = PH_OCT1;
				end
			end
			PH_OCT1, PH_OCT2: begin
				if (is_oct) begin
					acc_d     = {acc_q[4:0], b[2:0]};
					phase_mid = (phase_q == PH_OCT1) ? PH_OCT2 : PH_NORMAL;
				end else if (plain_bs) begin
					phase_mid = PH_BSLASH;
				end else if (plain_q) begin
					phase_mid = PH_QUOTE;
				end
			end
			PH_QUOTE: begin
				phase_mid = (b == CH_QUOTE) ? PH_NORMAL : PH_DROP;
			end
			default: begin
				if (plain_bs) begin
					phase_mid = PH_BSLASH;
				end else if (plain_q) begin
					phase_mid = PH_QUOTE;
				end
			end
		endcase
		// the final byte always leaves the decoder in normal phase
		phase_d = last ? PH_NORMAL : phase_mid;
	end

	// result words for this byte
	always_comb begin
		r0     = '0;
		r1     = '0;
		rcnt   = 2'd0;
		q_err  = 1'b0;
		tail   = 1'b0;
		tail_w = '0;
		unique case (phase_q) inside
			PH_DROP: begin
				rcnt = 2'd0;
			end
			PH_BSLASH: begin
				if (!is_oct) begin
					r0.out_byte = esc_byte;
					rcnt        = 2'd1;
				end
			end
			PH_OCT1, PH_OCT2: begin
				if (is_oct) begin
					if (phase_q == PH_OCT2) begin
						r0.out_byte = acc_d;
						rcnt        = 2'd1;
					end
				end else begin
					// pending octal value goes first, then the byte itself if it opens no escape
					r0.out_byte = acc_q;
					rcnt        = 2'd1;
					if (plain_emit) begin
						r1.out_byte = b;
						rcnt        = 2'd2;
					end
				end
			end
			PH_QUOTE: begin
				rcnt = 2'd1;
				if (b == CH_QUOTE) begin
					r0.out_byte = CH_QUOTE;
				end else begin
					// lone quote ends the string at once
					r0.status        = ST_LONE_QUOTE;
					r0.end_of_output = 1'b1;
					q_err            = 1'b1;
				end
			end
			default: begin
				if (plain_emit) begin
					r0.out_byte = b;
					rcnt        = 2'd1;
				end
			end
		endcase

		if (last && !q_err) begin
			// close whatever is still open at the end of the string
			if (phase_mid == PH_BSLASH) begin
				tail          = 1'b1;
				tail_w.status = ST_BSLASH_END;
			end else if (phase_mid == PH_QUOTE) begin
				tail          = 1'b1;
				tail_w.status = ST_LONE_QUOTE;
			end else if ((phase_mid == PH_OCT1) || (phase_mid == PH_OCT2)) begin
				tail            = 1'b1;
				tail_w.out_byte = acc_d;
			end
			if (tail) begin
				if (rcnt == 2'd0) begin
					r0   = tail_w;
					rcnt = 2'd1;
				end else begin
					r1   = tail_w;
					rcnt = 2'd2;
				end
			end
			if (rcnt == 2'd1) begin
				r0.end_of_output = 1'b1;
			end else if (rcnt == 2'd2) begin
				r1.end_of_output = 1'b1;
			end
		end
	end

	// the held byte is decoded once two buffer slots are free
	assign go        = valid_s1 && (cnt_q <= CNT_W'(OBUF_DEPTH - 2));
	assign src_stall = valid_s1 && !go;

	assign res_valid = (cnt_q != '0);
	assign res_word  = obuf_q[rd_ptr_q];
	assign pop       = res_valid && !res_stall;

	// mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_C;
		end else if (mode_we) begin
			mode_q <= mode_wdata;
		end
	end

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!src_stall) begin
			valid_s1 <= src_valid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (!src_stall && src_valid) begin
			word_s1 <= src_word;
		end
	end

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_NORMAL;
			acc_q   <= '0;
		end else if (go) begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
		end
	end

	// result buffer pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (go && (rcnt == 2'd1)) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end else if (go && (rcnt == 2'd2)) begin
				wr_ptr_q <= ptr_inc(ptr_inc(wr_ptr_q));
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			cnt_q <= cnt_q + (go ? CNT_W'(rcnt) : CNT_W'(0)) - CNT_W'(pop);
		end
	end

	// result buffer payload
	always_ff @(posedge clk) begin
		if (go && (rcnt != 2'd0)) begin
			obuf_q[wr_ptr_q] <= r0;
		end
		if (go && (rcnt == 2'd2)) begin
			obuf_q[ptr_inc(wr_ptr_q)] <= r1;
		end
	end

	// buffer never overfills
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(OBUF_DEPTH))
		else $error("result buffer count past depth");

	// the last byte of a string leaves the decoder in normal phase
	a_last_resets_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(go && last) |=> (phase_q == PH_NORMAL))
		else $error("phase not normal after final byte");

	// error words carry a zero byte and end the string
	a_err_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(go && (rcnt != 2'd0) && (r0.status != ST_OK)) |->
		(r0.end_of_output && (r0.out_byte == 8'd0)))
		else $error("error word without end mark or with data");

	// of two words from one byte the first is never an end word
	a_pair_first_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(go && (rcnt == 2'd2)) |-> ((r0.status == ST_OK) && !r0.end_of_output))
		else $error("first of two words ends the string");

endmodule

`default_nettype wire

// File: dv/testbench.sv
// testbench for the escaped string unescaper: directed and random strings against a predictor
`timescale 1ns / 100ps

module testbench;
	import esu_pkg::*;

	// mode codes past extended sql; both decode quotes only
	localparam logic [1:0] MODE_STD = 2'd2;
	localparam logic [1:0] MODE_ODD = 2'd3;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 8;
	localparam int LONG_HOLD    = 300;
	localparam int PHASE_ITEMS  = 130;
	localparam int RAND_PHASES  = 10;

	// scoreboard: decodes each accepted byte and holds the words it should produce
	class unescape_checker;
		logic [1:0] mode;
		phase_t     phase;
		logic [7:0] octal_acc;
		out_word_t  expected_words[$];
		out_word_t  step_words[3];
		int         step_count;
		int         mismatch_count;

		function new();
			mode = MODE_C;
			phase = PH_NORMAL;
			octal_acc = '0;
			step_count = 0;
			mismatch_count = 0;
		endfunction

		function void set_mode(logic [1:0] m);
			mode = m;
		endfunction

		function int pending();
			return expected_words.size();
		endfunction

		function void emit(logic [7:0] b, logic [1:0] st, logic eo);
			out_word_t w;
			w.out_byte = b;
			w.status = st;
			w.end_of_output = eo;
			step_words[step_count] = w;
			step_count++;
		endfunction

		function bit is_octal(logic [7:0] b);
			return b >= CH_ZERO && b <= CH_SEVEN;
		endfunction

		// a byte outside any escape: may open one, else passes through
		function void decode_plain(logic [7:0] b);
			if (b == CH_BSLASH && (mode == MODE_C || mode == MODE_EXT))
				phase = PH_BSLASH;
			else if (b == CH_QUOTE && mode != MODE_C)
				phase = PH_QUOTE;
			else
				emit(b, ST_OK, 1'b0);
		endfunction

		function void decode_byte(in_word_t w);
			logic [7:0] b;
			logic       is_last;
			bit         done;
			b = w.in_byte;
			is_last = w.end_of_input;
			done = 1'b0;
			step_count = 0;
			case (phase)
				PH_DROP: begin
					if (is_last)
						phase = PH_NORMAL;
					done = 1'b1;
				end
				PH_BSLASH: begin
					phase = PH_NORMAL;
					case (b)
						CH_LC_T: emit(CH_TAB, ST_OK, 1'b0);
						CH_LC_N: emit(CH_LF, ST_OK, 1'b0);
						CH_LC_R: emit(CH_CR, ST_OK, 1'b0);
						CH_LC_A: emit(CH_BEL, ST_OK, 1'b0);
						CH_LC_B: emit(CH_BS, ST_OK, 1'b0);
						default: begin
							if (is_octal(b)) begin
								octal_acc = {5'd0, b[2:0]};
								phase = PH_OCT1;
							end else begin
								emit(b, ST_OK, 1'b0);
							end
						end
					endcase
				end
				PH_OCT1, PH_OCT2: begin
					if (is_octal(b)) begin
						// shift in the digit, wrapping to eight bits
						octal_acc = {octal_acc[4:0], b[2:0]};
						if (phase == PH_OCT1) begin
							phase = PH_OCT2;
						end else begin
							emit(octal_acc, ST_OK, 1'b0);
							phase = PH_NORMAL;
						end
					end else begin
						// flush the pending value, then treat the byte afresh
						emit(octal_acc, ST_OK, 1'b0);
						phase = PH_NORMAL;
						decode_plain(b);
					end
				end
				PH_QUOTE: begin
					if (b == CH_QUOTE) begin
						emit(CH_QUOTE, ST_OK, 1'b0);
						phase = PH_NORMAL;
					end else begin
						// lone quote: error word ends the string, rest is dropped
						emit(8'h00, ST_LONE_QUOTE, 1'b1);
						phase = is_last ? PH_NORMAL : PH_DROP;
						done = 1'b1;
					end
				end
				default: begin
					phase = PH_NORMAL;
					decode_plain(b);
				end
			endcase
			if (!done && is_last) begin
				case (phase)
					PH_BSLASH: emit(8'h00, ST_BSLASH_END, 1'b1);
					PH_QUOTE: emit(8'h00, ST_LONE_QUOTE, 1'b1);
					PH_OCT1, PH_OCT2: emit(octal_acc, ST_OK, 1'b0);
					default: ;
				endcase
				phase = PH_NORMAL;
				if (step_count > 0)
					step_words[step_count - 1].end_of_output = 1'b1;
			end
			for (int i = 0; i < step_count; i++)
				expected_words.push_back(step_words[i]);
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			mismatch_count++;
		endtask

		task compare_word(out_word_t got);
			out_word_t want;
			if (expected_words.size() == 0) begin
				report($sformatf("unexpected word byte=%h status=%0d end=%0d",
					got.out_byte, got.status, got.end_of_output));
			end else begin
				want = expected_words.pop_front();
				if (got.out_byte !== want.out_byte)
					report($sformatf("out_byte got %h want %h", got.out_byte, want.out_byte));
				if (got.status !== want.status)
					report($sformatf("status got %0d want %0d", got.status, want.status));
				if (got.end_of_output !== want.end_of_output)
					report($sformatf("end_of_output got %0d want %0d",
						got.end_of_output, want.end_of_output));
			end
		endtask
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       mode_we = 1'b0;
	logic [1:0] mode_wdata = MODE_C;
	logic       src_valid = 1'b0;
	logic       src_stall;
	in_word_t   src_word = '0;
	logic       res_valid;
	logic       res_stall = 1'b0;
	out_word_t  res_word;

	unescape_checker scb = new();

	logic [7:0] str_q[$];      // bytes of the string being built
	int         items_sent = 0;
	int         cycle_count = 0;
	int         hold_req = 0;  // long receiver hold, picked up by the receiver process
	bit         tx_busy = 0;   // sender runs with no gaps while set
	bit         rx_busy = 0;   // receiver runs with no stalls while set

	escaped_string_unescaper_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.mode_we    (mode_we),
		.mode_wdata (mode_wdata),
		.src_valid  (src_valid),
		.src_stall  (src_stall),
		.src_word   (src_word),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res_word   (res_word)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// monitor: sample at the falling edge what the next rising edge will accept
	always @(negedge clk) begin
		if (arst_n) begin
			if (res_valid && !res_stall)
				scb.compare_word(res_word);
			if (src_valid && !src_stall)
				scb.decode_byte(src_word);
		end
	end

	// receiver: random stall before each word, runs of no stall, one long hold on request
	initial begin : receiver
		int wait_n;
		bit got;
		@(posedge clk);
		forever begin
			if (hold_req > 0) begin
				wait_n = hold_req;
				hold_req = 0;
			end else if (rx_busy) begin
				wait_n = 0;
			end else begin
				wait_n = $urandom_range(0, 15);
			end
			if ($urandom_range(0, 31) == 0)
				rx_busy = !rx_busy;
			if (wait_n > 0) begin
				res_stall <= 1'b1;
				repeat (wait_n) @(posedge clk);
				res_stall <= 1'b0;
			end
			// let one word through
			do begin
				@(negedge clk);
				got = res_valid;
				@(posedge clk);
			end while (!got);
		end
	end

	// offer one word after a random gap and hold it until accepted
	task send_byte(logic [7:0] b, logic eoi);
		int gap;
		bit ok;
		in_word_t w;
		gap = tx_busy ? 0 : $urandom_range(0, 15);
		if ($urandom_range(0, 31) == 0)
			tx_busy = !tx_busy;
		if (gap > 0) begin
			src_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		w.in_byte = b;
		w.end_of_input = eoi;
		src_valid <= 1'b1;
		src_word <= w;
		do begin
			@(negedge clk);
			ok = !src_stall;
			@(posedge clk);
		end while (!ok);
		items_sent++;
	endtask

	// send the built string, flag on its final byte
	task send_string();
		for (int i = 0; i < str_q.size(); i++)
			send_byte(str_q[i], i == str_q.size() - 1);
	endtask

	// wait until every expected word is out, then idle for DRAIN_CYCLES
	task drain();
		src_valid <= 1'b0;
		while (scb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task write_mode(logic [1:0] m);
		mode_we <= 1'b1;
		mode_wdata <= m;
		@(posedge clk);
		mode_we <= 1'b0;
		scb.set_mode(m);
	endtask

	// one well-formed piece of string body
	function automatic void add_token();
		logic [7:0] b;
		case ($urandom_range(0, 15))
			0, 1, 2, 3, 4, 5: begin
				b = 8'($urandom_range(0, 255));
				if (b == CH_BSLASH || b == CH_QUOTE)
					b = b ^ 8'h01;
				str_q.push_back(b);
			end
			6, 7: begin
				str_q.push_back(CH_BSLASH);
				case ($urandom_range(0, 4))
					0: str_q.push_back(CH_LC_T);
					1: str_q.push_back(CH_LC_N);
					2: str_q.push_back(CH_LC_R);
					3: str_q.push_back(CH_LC_A);
					default: str_q.push_back(CH_LC_B);
				endcase
			end
			8, 9: begin
				// octal escape of one to three digits
				str_q.push_back(CH_BSLASH);
				repeat ($urandom_range(1, 3))
					str_q.push_back(CH_ZERO + 8'($urandom_range(0, 7)));
			end
			10: begin
				str_q.push_back(CH_BSLASH);
				str_q.push_back(8'($urandom_range(0, 255)));
			end
			11, 12: begin
				str_q.push_back(CH_QUOTE);
				str_q.push_back(CH_QUOTE);
			end
			13: str_q.push_back(8'($urandom_range(CH_ZERO, CH_SEVEN + 8'd2)));
			default: str_q.push_back(8'($urandom_range(CH_LC_A, CH_LC_A + 8'd25)));
		endcase
	endfunction

	// mostly well-formed strings, some with a broken ending, a few pure noise
	function automatic void build_string();
		int kind;
		logic [7:0] b;
		str_q.delete();
		kind = $urandom_range(0, 15);
		if (kind == 0) begin
			repeat ($urandom_range(1, 10))
				str_q.push_back(8'($urandom_range(0, 255)));
		end else begin
			repeat (($urandom_range(0, 15) == 0) ? $urandom_range(1, 30) : $urandom_range(1, 6))
				add_token();
			if (kind <= 2) begin
				case ($urandom_range(0, 2))
					0: str_q.push_back(CH_BSLASH);
					1: str_q.push_back(CH_QUOTE);
					default: begin
						// lone quote in the middle, tail gets dropped
						b = 8'($urandom_range(0, 255));
						if (b == CH_QUOTE)
							b = b ^ 8'h01;
						str_q.push_back(CH_QUOTE);
						str_q.push_back(b);
						repeat ($urandom_range(1, 4))
							add_token();
					end
				endcase
			end
		end
	endfunction

	initial begin : stimulus
		int phase_start;
		logic [1:0] m;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// c mode: simple escapes
		write_mode(MODE_C);
		str_q = '{CH_BSLASH, CH_LC_T, CH_BSLASH, CH_LC_N, CH_BSLASH, CH_LC_R,
			CH_BSLASH, CH_LC_A, CH_BSLASH, CH_LC_B};
		send_string();
		// zero byte, octal wrap, short octal cut by a backslash, escaped 0xff
		str_q = '{8'h00, CH_BSLASH, CH_SEVEN, CH_SEVEN, CH_SEVEN,
			CH_BSLASH, CH_ZERO + 8'd1, CH_BSLASH, 8'hff};
		send_string();
		// octal pending at the end of the string
		str_q = '{CH_BSLASH, CH_ZERO + 8'd5};
		send_string();
		// trailing backslash
		str_q = '{CH_BSLASH};
		send_string();
		drain();

		// extended sql: doubled quote then a quote at the end
		write_mode(MODE_EXT);
		str_q = '{CH_QUOTE, CH_QUOTE, CH_QUOTE};
		send_string();
		// lone quote mid-stream, the rest is dropped
		str_q = '{CH_QUOTE, 8'h41, 8'h42};
		send_string();
		drain();

		// mode three: backslash is a plain byte
		write_mode(MODE_ODD);
		str_q = '{CH_BSLASH};
		send_string();
		drain();

		// random phases over all modes, extremes first
		for (int p = 0; p < RAND_PHASES; p++) begin
			case (p)
				0: m = MODE_C;
				1: m = MODE_EXT;
				2: m = MODE_STD;
				3: m = MODE_ODD;
				default: m = 2'($urandom_range(0, 3));
			endcase
			write_mode(m);
			if (p == 1) begin
				// receiver holds off while the sender keeps offering
				tx_busy = 1'b1;
				hold_req = LONG_HOLD;
			end
			phase_start = items_sent;
			while (items_sent - phase_start < PHASE_ITEMS) begin
				build_string();
				send_string();
			end
			drain();
		end

		if (scb.mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// File: escaped_string_unescaper_core.f
rtl/esu_pkg.sv
rtl/escaped_string_unescaper_core.sv
dv/testbench.sv
